@@ hw/rtl/can_bts_pkg.sv @@
package can_bts_pkg;

  // Fixed field widths
  localparam int RATE_W  = 20;
  localparam int CLOCK_W = 32;

  // Serial divider geometry: one quotient bit per cycle
  localparam int DIV_W  = 32;
  localparam int STEP_W = $clog2(DIV_W);

  // Limits of the register encodings
  localparam logic [10:0] FIELD_PRESC_MAX = 11'd256;
  localparam logic [7:0]  FIELD_SEG_MAX   = 8'd8;
  localparam logic [6:0]  FIELD_RJW_MAX   = 7'd4;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd60000000;

  // Control sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_GO,
    S_Q_WAIT,
    S_LOOP,
    S_P_GO,
    S_P_WAIT,
    S_F_GO,
    S_F_WAIT,
    S_A_GO,
    S_A_WAIT,
    S_CMP,
    S_NEXT,
    S_FIN
  } state_t;

  // Divider result bundle
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_out_t;

  // Encoded timing result
  typedef struct packed {
    logic       err;
    logic [7:0] presc_m1;
    logic [1:0] rjw_m1;
    logic [2:0] ph1_m1;
    logic [2:0] ph2_m1;
    logic [2:0] prop_m1;
  } seg_t;

endpackage

@@ hw/rtl/can_bit_timing_solver_top.sv @@
// CAN bit timing solver.
// Config: write the CAN engine clock in Hz on cfg_clock_hz with cfg_valid;
// cfg_ready is always high. Reset value is 60 MHz. Write only while idle.
// Input: one beat on in_valid/in_stall carries the requested bitrate.
// Output: one beat on out_valid/out_stall per input beat: status (1 = error,
// all other fields zero) and minus-one encoded prescaler, RJW, phase1,
// phase2 and propagation segment.
// Search: one shared 32-bit restoring divider makes one quotient bit per
// cycle. The ratio clock/bitrate takes one divide; each quanta count from
// MAX_QUANTA down to MIN_QUANTA takes up to three divides plus the launch,
// compare and step states of the sequencer. An exact prescaler hit ends the
// search early. One item is in work at a time.
// in_stall is low while the sequencer is idle. A finished result waits in
// the output register while out_stall is high; the next item is accepted
// meanwhile, and its result waits until the register is free.
// Reset (synchronous, active low) returns to idle and drops any result.
module can_bit_timing_solver_top
  import can_bts_pkg::*;
#(
  parameter int MIN_QUANTA     = 8,
  parameter int MAX_QUANTA     = 25,
  parameter int MAX_PROP_SEG   = 8,
  parameter int MIN_PHASE2     = 2,
  parameter int MAX_JUMP_WIDTH = 4,
  parameter int MAX_PRESCALER  = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CLOCK_W-1:0] cfg_clock_hz,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [RATE_W-1:0]  in_bitrate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic [7:0]         out_prescaler_minus_one,
  output logic [1:0]         out_resync_width_minus_one,
  output logic [2:0]         out_phase1_minus_one,
  output logic [2:0]         out_phase2_minus_one,
  output logic [2:0]         out_propagation_minus_one
);

  localparam int CW = $clog2(MAX_QUANTA + 1);
  localparam int PW = $clog2(MAX_PRESCALER + 1);

  state_t state_r, state_nxt;

  logic [CLOCK_W-1:0] clock_r, clock_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;
  logic [DIV_W-1:0]   q_r, q_nxt;
  logic [DIV_W-1:0]   diff_r, diff_nxt;
  logic [DIV_W-1:0]   lowest_r, lowest_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      best_r, best_nxt;
  logic [PW-1:0]      p_r, p_nxt;
  logic [PW-1:0]      pbest_r, pbest_nxt;
  seg_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               in_fire, out_free;
  logic               div_start;
  logic [DIV_W-1:0]   div_a, div_b;
  div_out_t           div_res;
  seg_t               seg;
  logic               p_skip, below_min;
  logic [DIV_W-1:0]   rate_ext;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign rate_ext  = DIV_W'(rate_r);
  assign p_skip    = (div_res.quo == '0) || (div_res.quo > DIV_W'(MAX_PRESCALER));
  assign below_min = 6'(cnt_r) < 6'(MIN_QUANTA);

  can_bts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .res      (div_res)
  );

  can_bts_seg #(
    .MIN_QUANTA     (MIN_QUANTA),
    .MAX_QUANTA     (MAX_QUANTA),
    .MAX_PROP_SEG   (MAX_PROP_SEG),
    .MIN_PHASE2     (MIN_PHASE2),
    .MAX_JUMP_WIDTH (MAX_JUMP_WIDTH),
    .MAX_PRESCALER  (MAX_PRESCALER)
  ) u_seg (
    .best  (best_r),
    .presc (pbest_r),
    .seg   (seg)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_bitrate == '0) ? S_FIN : S_Q_GO;
        end
      end
      S_Q_GO:   state_nxt = S_Q_WAIT;
      S_Q_WAIT: begin
        if (div_res.done) begin
          state_nxt = (div_res.quo < DIV_W'(MIN_QUANTA - 1)) ? S_FIN : S_LOOP;
        end
      end
      S_LOOP:   state_nxt = below_min ? S_FIN : S_P_GO;
      S_P_GO:   state_nxt = S_P_WAIT;
      S_P_WAIT: begin
        if (div_res.done) begin
          if (p_skip) begin
            state_nxt = S_NEXT;
          end else if (div_res.rem == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_F_GO;
          end
        end
      end
      S_F_GO:   state_nxt = S_F_WAIT;
      S_F_WAIT: if (div_res.done) state_nxt = S_A_GO;
      S_A_GO:   state_nxt = S_A_WAIT;
      S_A_WAIT: if (div_res.done) state_nxt = S_CMP;
      S_CMP:    state_nxt = S_NEXT;
      S_NEXT:   state_nxt = S_LOOP;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and divider launch
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    div_a     = clock_r;
    div_b     = rate_ext;
    case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_Q_GO: begin
        div_start = 1'b1;
        div_a     = clock_r;
        div_b     = rate_ext;
      end
      S_P_GO: begin
        div_start = 1'b1;
        div_a     = q_r;
        div_b     = DIV_W'(cnt_r);
      end
      S_F_GO: begin
        div_start = 1'b1;
        div_a     = clock_r;
        div_b     = DIV_W'(p_r);
      end
      S_A_GO: begin
        div_start = 1'b1;
        div_a     = div_res.quo;
        div_b     = DIV_W'(cnt_r);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Datapath registers
  always_comb begin
    clock_nxt     = clock_r;
    rate_nxt      = rate_r;
    q_nxt         = q_r;
    diff_nxt      = diff_r;
    lowest_nxt    = lowest_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    p_nxt         = p_r;
    pbest_nxt     = pbest_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_valid && cfg_ready) begin
      clock_nxt = cfg_clock_hz;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rate_nxt   = in_bitrate;
          lowest_nxt = DIV_W'(in_bitrate);
          best_nxt   = '0;
          pbest_nxt  = '0;
        end
      end
      S_Q_WAIT: begin
        if (div_res.done) begin
          q_nxt   = div_res.quo;
          cnt_nxt = CW'(MAX_QUANTA);
        end
      end
      S_P_WAIT: begin
        if (div_res.done && !p_skip) begin
          p_nxt = PW'(div_res.quo);
          if (div_res.rem == '0) begin
            best_nxt  = cnt_r;
            pbest_nxt = PW'(div_res.quo);
          end
        end
      end
      S_A_WAIT: begin
        if (div_res.done) begin
          diff_nxt = (div_res.quo > rate_ext) ? (div_res.quo - rate_ext)
                                              : (rate_ext - div_res.quo);
        end
      end
      // Closer achieved bitrate wins; ties keep the higher count
      S_CMP: begin
        if (diff_r < lowest_r) begin
          lowest_nxt = diff_r;
          best_nxt   = cnt_r;
          pbest_nxt  = p_r;
        end
      end
      S_NEXT: cnt_nxt = cnt_r - 1'b1;
      S_FIN: begin
        if (out_free) begin
          res_nxt       = seg;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clock_r     <= CLOCK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rate_r   <= rate_nxt;
    q_r      <= q_nxt;
    diff_r   <= diff_nxt;
    lowest_r <= lowest_nxt;
    cnt_r    <= cnt_nxt;
    best_r   <= best_nxt;
    p_r      <= p_nxt;
    pbest_r  <= pbest_nxt;
    res_r    <= res_nxt;
  end

  // Output beat
  assign out_valid                  = out_valid_r;
  assign out_status                 = res_r.err;
  assign out_prescaler_minus_one    = res_r.presc_m1;
  assign out_resync_width_minus_one = res_r.rjw_m1;
  assign out_phase1_minus_one       = res_r.ph1_m1;
  assign out_phase2_minus_one       = res_r.ph2_m1;
  assign out_propagation_minus_one  = res_r.prop_m1;

  // Error beats carry all-zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_prescaler_minus_one == '0) &&
      (out_resync_width_minus_one == '0) && (out_phase1_minus_one == '0) &&
      (out_phase2_minus_one == '0) && (out_propagation_minus_one == '0))
    else $error("error beat with nonzero fields");

  // Divider completes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_Q_WAIT) || (state_r == S_P_WAIT) ||
      (state_r == S_F_WAIT) || (state_r == S_A_WAIT))
    else $error("divider result outside a wait state");

  // A chosen count lies in the searched range with a usable prescaler
  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && (best_r != '0) |->
      (6'(best_r) >= 6'(MIN_QUANTA)) && (6'(best_r) <= 6'(MAX_QUANTA)) &&
      (pbest_r != '0))
    else $error("chosen quanta count out of range");

  // A waiting result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(res_r))
    else $error("stalled result changed");

endmodule

@@ hw/rtl/can_bts_div.sv @@
module can_bts_div
  import can_bts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output div_out_t         res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_W:0]    trial;

  // Restoring step: shift in next dividend bit, try subtract
  assign trial = {rem_r, quo_r[DIV_W-1]} - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DIV_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial[DIV_W]) begin
        rem_nxt = {rem_r[DIV_W-2:0], quo_r[DIV_W-1]};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

@@ hw/rtl/can_bts_seg.sv @@
module can_bts_seg
  import can_bts_pkg::*;
#(
  parameter int MIN_QUANTA     = 8,
  parameter int MAX_QUANTA     = 25,
  parameter int MAX_PROP_SEG   = 8,
  parameter int MIN_PHASE2     = 2,
  parameter int MAX_JUMP_WIDTH = 4,
  parameter int MAX_PRESCALER  = 256,
  localparam int CW = $clog2(MAX_QUANTA + 1),
  localparam int PW = $clog2(MAX_PRESCALER + 1)
) (
  input  logic [CW-1:0] best,
  input  logic [PW-1:0] presc,
  output seg_t          seg
);

  localparam logic [6:0] MQ  = 7'(MIN_QUANTA);
  localparam logic [6:0] MPS = 7'(MAX_PROP_SEG);
  localparam logic [6:0] MP2 = 7'(MIN_PHASE2);
  localparam logic [6:0] MJW = 7'(MAX_JUMP_WIDTH);

  logic [6:0]  b, rest, ph1, ph2, rjw;
  logic [7:0]  used, prop;
  logic [10:0] pb, pm1;
  logic        bad;

  // Split the bit into sync, propagation and phase segments
  always_comb begin
    b    = 7'(best);
    rest = (b > MPS) ? (b - MPS) : 7'd0;
    ph2  = {1'b0, rest[6:1]};
    if (ph2 < MP2) begin
      ph2 = MP2;
    end
    ph1  = (b == MQ) ? 7'd1 : ph2;
    used = {1'b0, ph1} + {1'b0, ph2} + 8'd1;
    prop = {1'b0, b} - used;
    rjw  = (ph1 < MJW) ? ph1 : MJW;
    pb   = 11'(presc);
    pm1  = pb - 11'd1;

    bad = (best == '0) || (pb == '0) || (pb > FIELD_PRESC_MAX) ||
          ({1'b0, b} <= used) || (prop > FIELD_SEG_MAX) ||
          (ph1 == '0) || ({1'b0, ph1} > FIELD_SEG_MAX) ||
          (ph2 == '0) || ({1'b0, ph2} > FIELD_SEG_MAX) ||
          (rjw == '0) || (rjw > FIELD_RJW_MAX);
  end

  // Minus-one encodings, all zero on error
  always_comb begin
    seg = '0;
    seg.err = bad;
    if (!bad) begin
      seg.presc_m1 = pm1[7:0];
      seg.rjw_m1   = 2'(rjw - 7'd1);
      seg.ph1_m1   = 3'(ph1 - 7'd1);
      seg.ph2_m1   = 3'(ph2 - 7'd1);
      seg.prop_m1  = 3'(prop - 8'd1);
    end
  end

endmodule

@@ tb/sv/can_bts_checker.sv @@
`timescale 1ns / 100ps

module can_bts_checker
  import can_bts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CLOCK_W-1:0] cfg_clock_hz,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [RATE_W-1:0]  in_bitrate,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_status,
  input  logic [7:0]         out_prescaler_minus_one,
  input  logic [1:0]         out_resync_width_minus_one,
  input  logic [2:0]         out_phase1_minus_one,
  input  logic [2:0]         out_phase2_minus_one,
  input  logic [2:0]         out_propagation_minus_one,
  output int                 pending,
  output int                 fails
);

  // Solver limits, matching the block's default parameters
  localparam int MIN_Q       = 8;
  localparam int MAX_Q       = 25;
  localparam int PROP_MAX    = 8;
  localparam int PH2_MIN     = 2;
  localparam int SJW_MAX     = 4;
  localparam int PRESC_LIMIT = 256;
  localparam int SEG_LIMIT   = 8;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam int SHOW_LIMIT = 10;

  logic [CLOCK_W-1:0] engine_hz;
  seg_t               timing_due[$];
  int                 bad_count = 0;

  // Bit timing search: exact prescaler hit wins, else closest achieved rate
  function automatic seg_t solve_timing(input logic [RATE_W-1:0] rate,
                                        input logic [CLOCK_W-1:0] hz);
    seg_t        res;
    logic [31:0] ratio, presc, achieved, miss, closest, winner;
    logic [31:0] rest, ph1, ph2, sjw;
    int          prop;
    res     = '0;
    res.err = STATUS_ERR;
    if (rate == '0) return res;
    ratio = hz / 32'(rate);
    if (ratio < 32'(MIN_Q - 1)) return res;

    closest = 32'(rate);
    winner  = '0;
    for (int n = MAX_Q; n >= MIN_Q; n--) begin
      presc = ratio / 32'(n);
      if (presc == '0 || presc > 32'(PRESC_LIMIT)) continue;
      if (presc * 32'(n) == ratio) begin
        winner = 32'(n);
        break;
      end
      achieved = (hz / presc) / 32'(n);
      miss = (achieved > 32'(rate)) ? achieved - 32'(rate) : 32'(rate) - achieved;
      if (miss < closest) begin
        closest = miss;
        winner  = 32'(n);
      end
    end
    if (winner == '0) return res;

    presc = ratio / winner;
    if (presc == '0 || presc > 32'(PRESC_LIMIT)) return res;

    // Segment split; sync takes one quantum
    rest = (winner > 32'(PROP_MAX)) ? winner - 32'(PROP_MAX) : '0;
    ph2  = rest / 2;
    if (ph2 < 32'(PH2_MIN)) ph2 = 32'(PH2_MIN);
    ph1  = (winner == 32'(MIN_Q)) ? 32'd1 : ph2;
    prop = int'(winner) - int'(ph1) - int'(ph2) - 1;
    sjw  = (ph1 < 32'(SJW_MAX)) ? ph1 : 32'(SJW_MAX);

    if (prop < 1 || prop > SEG_LIMIT) return res;
    if (ph1 < 1 || ph1 > 32'(SEG_LIMIT) || ph2 < 1 || ph2 > 32'(SEG_LIMIT)) return res;
    if (sjw < 1 || sjw > 32'(SJW_MAX)) return res;

    res.err      = STATUS_OK;
    res.presc_m1 = 8'(presc - 1);
    res.rjw_m1   = 2'(sjw - 1);
    res.ph1_m1   = 3'(ph1 - 1);
    res.ph2_m1   = 3'(ph2 - 1);
    res.prop_m1  = 3'(prop - 1);
    return res;
  endfunction

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      if (bad_count < SHOW_LIMIT)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      bad_count++;
    end
  endtask

  // Track register writes, predict accepted beats, check returned beats
  always @(posedge clk) begin : watch
    seg_t want;
    if (!rst_n) begin
      engine_hz <= CLOCK_RESET;
      timing_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) engine_hz <= cfg_clock_hz;
      if (in_valid && !in_stall) timing_due.push_back(solve_timing(in_bitrate, engine_hz));
      if (out_valid && !out_stall) begin
        if (timing_due.size() == 0) begin
          if (bad_count < SHOW_LIMIT)
            $display("%0t: result beat with nothing outstanding", $time);
          bad_count++;
        end else begin
          want = timing_due.pop_front();
          compare_field("status", want.err, out_status);
          compare_field("prescaler", want.presc_m1, out_prescaler_minus_one);
          compare_field("rjw", want.rjw_m1, out_resync_width_minus_one);
          compare_field("phase1", want.ph1_m1, out_phase1_minus_one);
          compare_field("phase2", want.ph2_m1, out_phase2_minus_one);
          compare_field("propagation", want.prop_m1, out_propagation_minus_one);
        end
      end
    end
    pending <= timing_due.size();
    fails   <= bad_count;
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import can_bts_pkg::*;

  localparam int                 IDLE_LIMIT = 20000;
  localparam logic [RATE_W-1:0]  RATE_TOP   = '1;
  localparam logic [CLOCK_W-1:0] CLOCK_TOP  = '1;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CLOCK_W-1:0] cfg_clock_hz;
  logic               in_valid;
  logic               in_stall;
  logic [RATE_W-1:0]  in_bitrate;
  logic               out_valid;
  logic               out_stall;
  logic               out_status;
  logic [7:0]         out_prescaler_minus_one;
  logic [1:0]         out_resync_width_minus_one;
  logic [2:0]         out_phase1_minus_one;
  logic [2:0]         out_phase2_minus_one;
  logic [2:0]         out_propagation_minus_one;

  int                 pending;
  int                 fails;
  int                 idle_cycles = 0;
  int                 tx_calm = 0;
  int                 rx_calm = 0;
  int                 rx_wait;
  logic [CLOCK_W-1:0] cur_hz = CLOCK_RESET;

  // Usual bus bitrates
  logic [RATE_W-1:0] std_rates [0:10] = '{
    20'd10000, 20'd20000, 20'd33333, 20'd50000, 20'd83333, 20'd100000,
    20'd125000, 20'd250000, 20'd500000, 20'd800000, 20'd1000000
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  can_bit_timing_solver_top dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_clock_hz               (cfg_clock_hz),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_bitrate                 (in_bitrate),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_status                 (out_status),
    .out_prescaler_minus_one    (out_prescaler_minus_one),
    .out_resync_width_minus_one (out_resync_width_minus_one),
    .out_phase1_minus_one       (out_phase1_minus_one),
    .out_phase2_minus_one       (out_phase2_minus_one),
    .out_propagation_minus_one  (out_propagation_minus_one)
  );

  can_bts_checker timing_chk (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_clock_hz               (cfg_clock_hz),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_bitrate                 (in_bitrate),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_status                 (out_status),
    .out_prescaler_minus_one    (out_prescaler_minus_one),
    .out_resync_width_minus_one (out_resync_width_minus_one),
    .out_phase1_minus_one       (out_phase1_minus_one),
    .out_phase2_minus_one       (out_phase2_minus_one),
    .out_propagation_minus_one  (out_propagation_minus_one),
    .pending                    (pending),
    .fails                      (fails)
  );

  // Result side: random stall before each beat, with calm stretches
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_calm > 0) begin
        rx_calm--;
        rx_wait = 0;
      end else begin
        rx_wait = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0) rx_calm = 12;
      end
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        repeat (rx_wait) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: no beat on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input beat after a random gap
  task automatic send_rate(input logic [RATE_W-1:0] rate);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0) tx_calm = 12;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_bitrate <= rate;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_clock(input logic [CLOCK_W-1:0] hz);
    wait_drained();
    cfg_valid    <= 1'b1;
    cfg_clock_hz <= hz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_hz = hz;
  endtask

  // Mostly usable bitrates: bus standards and exact divisions of the clock
  function automatic logic [RATE_W-1:0] pick_rate();
    int                 sel;
    logic [CLOCK_W-1:0] div;
    logic [CLOCK_W-1:0] rate;
    sel = $urandom_range(0, 99);
    if (sel < 35) return std_rates[$urandom_range(0, 10)];
    if (sel < 60) begin
      div  = $urandom_range(1, 256) * $urandom_range(8, 25);
      rate = cur_hz / div;
      if (rate != '0 && rate <= CLOCK_W'(RATE_TOP)) return rate[RATE_W-1:0];
    end
    if (sel < 85) return RATE_W'($urandom_range(0, RATE_TOP));
    return RATE_W'($urandom_range(0, 2000));
  endfunction

  task automatic run_phase(input int items);
    for (int k = 0; k < items; k++) send_rate(pick_rate());
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_clock_hz = '0;
    in_valid     = 1'b0;
    in_bitrate   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset clock: zero rate, slowest rate with no usable prescaler, field top
    send_rate(20'd0);
    send_rate(20'd1);
    send_rate(20'd234);
    send_rate(20'd10000);
    send_rate(20'd83333);
    send_rate(20'd125000);
    send_rate(20'd250000);
    send_rate(20'd500000);
    send_rate(20'd1000000);
    send_rate(RATE_TOP);

    // High counts give zero prescalers; best count below the maximum
    set_clock(32'd16000000);
    send_rate(20'd1000000);
    send_rate(RATE_TOP);

    // Shortest bit at the minimum count; ratio just at the low bound
    set_clock(32'd8000000);
    send_rate(20'd1000000);
    send_rate(RATE_TOP);

    // Clock too slow for any rate
    set_clock(32'd1);
    send_rate(20'd1);
    send_rate(RATE_TOP);

    // Fastest clock: prescaler overflow and prescaler of exactly 256
    set_clock(CLOCK_TOP);
    send_rate(20'd1);
    send_rate(RATE_TOP);
    send_rate(20'd1000000);

    // Random part over several clock settings
    set_clock(CLOCK_RESET);
    run_phase(40);
    wait_drained();
    run_phase(40);
    set_clock(32'd80000000);
    run_phase(40);
    set_clock(32'd24000000);
    run_phase(40);
    set_clock(CLOCK_W'($urandom_range(1, CLOCK_TOP)));
    run_phase(40);
    set_clock(CLOCK_TOP);
    run_phase(30);
    set_clock(32'd1);
    run_phase(10);
    set_clock(CLOCK_W'($urandom_range(1, 10000000)));
    run_phase(40);
    set_clock(32'd40000000);
    run_phase(20);

    wait_drained();
    repeat (100) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
